FILE: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Width of every operand port.
    localparam int FIELD_W = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PREP,
        ST_DBL,
        ST_ADD,
        ST_STEP,
        ST_FINISH
    } state_t;

    // Control for the remainder unit.
    typedef struct packed {
        logic load;
        logic step;
    } rem_ctrl_t;

    // Control for the modular multiply units.
    typedef struct packed {
        logic clear;
        logic dbl;
        logic add;
        logic mbit;
    } mul_ctrl_t;

endpackage

`default_nettype wire

FILE: design/mexp_rem.sv
// ----------------------------------------------------------------------------
// Modular exponentiation remainder unit
// Restoring bit-serial remainder: one dividend bit enters per cycle while step is asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_rem #(
    parameter int WIDTH = 64
) (
    input  wire logic               clk,
    input  mexp_pkg::rem_ctrl_t     ctrl,
    input  wire logic [WIDTH-1:0]   dividend,
    input  wire logic [WIDTH-1:0]   modulus,
    output logic      [WIDTH-1:0]   remainder
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] div_reg;
    logic [WIDTH-1:0] div_next;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] r_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH+1:0] diff;

    // Bring in the next dividend bit and subtract the modulus if it fits.
    always_comb
    begin
        trial = {r_reg, div_reg[WIDTH-1]};
        diff  = {1'b0, trial} - {2'b00, modulus};
        div_next = div_reg;
        r_next   = r_reg;
        if (ctrl.load)
        begin
            div_next = dividend;
            r_next   = '0;
        end
        else if (ctrl.step)
        begin
            div_next = {div_reg[WIDTH-2:0], 1'b0};
            r_next   = diff[WIDTH+1] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        r_reg   <= r_next;
    end

    assign remainder = r_reg;

endmodule

`default_nettype wire

FILE: design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular exponentiation multiply unit
// Shift-and-add modular product: one doubling or one addition per cycle while dbl or add is asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod #(
    parameter int WIDTH = 64
) (
    input  wire logic               clk,
    input  mexp_pkg::mul_ctrl_t     ctrl,
    input  wire logic [WIDTH-1:0]   addend,
    input  wire logic [WIDTH-1:0]   modulus,
    output logic      [WIDTH-1:0]   product
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] operand;
    logic [WIDTH:0]   sum;
    logic [WIDTH+1:0] diff;

    // Modular add of the accumulator and either itself or the addend.
    // Both operands are below the modulus, so one subtraction suffices.
    always_comb
    begin
        operand = ctrl.dbl ? acc_reg : addend;
        sum     = {1'b0, acc_reg} + {1'b0, operand};
        diff    = {1'b0, sum} - {2'b00, modulus};
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.dbl || (ctrl.add && ctrl.mbit))
        begin
            acc_next = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
        end
    end

    // Accumulator.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: design/modular_exponentiation.sv
// A zero modulus or zero exponent goes straight to the finish state.
// Throughput: one item at a time, bounded by the shift-and-add multiply
// units. A new beat is taken while a result waits. Reset clears the
// sequencer and the output valid.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left binary exponentiation with bit-serial modular multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
    parameter int WIDTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mexp_pkg::FIELD_W-1:0]   base_value,
    input  wire logic [mexp_pkg::FIELD_W-1:0]   power,
    input  wire logic [mexp_pkg::FIELD_W-1:0]   modulus_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [mexp_pkg::FIELD_W-1:0]   result_value,
    output logic                                modulus_error
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] m_next;
    logic [WIDTH-1:0] e_reg;
    logic [WIDTH-1:0] e_next;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] b_next;
    logic [WIDTH-1:0] y_reg;
    logic [WIDTH-1:0] y_next;
    logic [WIDTH-1:0] mbits_reg;
    logic [WIDTH-1:0] mbits_next;
    logic             err_reg;
    logic             err_next;
    logic [WIDTH-1:0] res_reg;
    logic [WIDTH-1:0] res_next;
    logic             res_err_reg;
    logic             res_err_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [WIDTH-1:0] m_in;
    logic [WIDTH-1:0] e_in;
    logic [WIDTH-1:0] b_in;
    logic             accept;
    logic             cnt_last;
    logic             out_free;
    logic [WIDTH-1:0] e_shift;
    logic [WIDTH-1:0] rem_out;
    logic [WIDTH-1:0] y_prod;
    logic [WIDTH-1:0] b_prod;

    rem_ctrl_t        rem_ctrl;
    mul_ctrl_t        mul_ctrl;

    assign m_in     = modulus_value[WIDTH-1:0];
    assign e_in     = power[WIDTH-1:0];
    assign b_in     = base_value[WIDTH-1:0];
    assign accept   = in_valid && !in_stall;
    assign cnt_last = (cnt_reg == CNT_LAST);
    assign out_free = !out_valid_reg || !out_stall;
    assign e_shift  = e_reg >> 1;

    // Base reduction modulo the modulus.
    mexp_rem #(
        .WIDTH     (WIDTH)
    ) u_rem (
        .clk       (clk),
        .ctrl      (rem_ctrl),
        .dividend  (b_in),
        .modulus   (m_reg),
        .remainder (rem_out)
    );

    // Accumulator times running base.
    mexp_mulmod #(
        .WIDTH   (WIDTH)
    ) u_mul_y (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .addend  (y_reg),
        .modulus (m_reg),
        .product (y_prod)
    );

    // Running base squared.
    mexp_mulmod #(
        .WIDTH   (WIDTH)
    ) u_mul_b (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .addend  (b_reg),
        .modulus (m_reg),
        .product (b_prod)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if ((m_in == '0) || (e_in == '0))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (cnt_last)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_DBL;
            end
            ST_DBL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (cnt_last)
                    state_next = ST_STEP;
                else
                    state_next = ST_DBL;
            end
            ST_STEP:
            begin
                if (e_shift == '0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DBL;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Unit controls decoded from the state.
    always_comb
    begin
        rem_ctrl.load  = accept;
        rem_ctrl.step  = (state_reg == ST_REDUCE);
        mul_ctrl.clear = (state_reg == ST_PREP) || (state_reg == ST_STEP);
        mul_ctrl.dbl   = (state_reg == ST_DBL);
        mul_ctrl.add   = (state_reg == ST_ADD);
        mul_ctrl.mbit  = mbits_reg[WIDTH-1];
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        b_next         = b_reg;
        y_next         = y_reg;
        mbits_next     = mbits_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    m_next   = m_in;
                    e_next   = e_in;
                    err_next = (m_in == '0);
                    // Exponent zero with a nonzero modulus leaves 1 unreduced; a unit modulus
                    // otherwise reduces everything to 0.
                    if (m_in == '0)
                        y_next = '0;
                    else if ((e_in != '0) && (m_in == WIDTH'(1)))
                        y_next = '0;
                    else
                        y_next = WIDTH'(1);
                end
            end
            ST_REDUCE:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                b_next     = rem_out;
                mbits_next = rem_out;
            end
            ST_ADD:
            begin
                cnt_next   = cnt_reg + 1'b1;
                mbits_next = {mbits_reg[WIDTH-2:0], 1'b0};
            end
            ST_STEP:
            begin
                cnt_next   = '0;
                e_next     = e_shift;
                b_next     = b_prod;
                mbits_next = b_prod;
                if (e_reg[0])
                    y_next = y_prod;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_next       = y_reg;
                    res_err_next   = err_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        m_reg       <= m_next;
        e_reg       <= e_next;
        b_reg       <= b_next;
        y_reg       <= y_next;
        mbits_reg   <= mbits_next;
        err_reg     <= err_next;
        res_reg     <= res_next;
        res_err_reg <= res_err_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_value  = FIELD_W'(res_reg);
    assign modulus_error = res_err_reg;

endmodule

`default_nettype wire
